@@ rtl/lmi4_pkg.sv @@
// Shared constants and types of the four-axis linear move interpolator.
`default_nettype none
package lmi4_pkg;

    localparam int AXES        = 4;
    localparam int POS_W       = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FEED_W      = 16;
    localparam int MS_W        = 32;
    localparam int DIST_W      = 16;
    // per-axis span |target - start|
    localparam int SPAN_W      = POS_W;
    // move length and distance travelled while a move runs
    localparam int LEN_W       = SPAN_W + 1;
    localparam int MOVED_W     = LEN_W;
    localparam int SQ_W        = 2 * SPAN_W;
    localparam int RAD_W       = SQ_W + 2;
    localparam int PROD_W      = FEED_W + MS_W;
    localparam int CDIV_W      = PROD_W + FRAC_BITS;
    localparam int CNT_W       = 7;
    localparam int MS_PER_MIN  = 60000;
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd66;

    // distance = feed * elapsed * 2^FRAC_BITS / 60000
    //          = (feed * elapsed << (FRAC_BITS - 5)) / 1875
    localparam int CDIV_SH     = FRAC_BITS - 5;
    localparam int CDIV_DIV    = MS_PER_MIN >> 5;
    // quotient digit per step and the steps over the whole dividend
    localparam int CDIV_DIG    = 16;
    localparam int CDIV_STEPS  = CDIV_W / CDIV_DIG;
    localparam int CDIV_REM_W  = $clog2(CDIV_DIV);
    localparam int CDIV_X_W    = CDIV_REM_W + CDIV_DIG;
    // reciprocal of the divisor, exact for any step value below 2^CDIV_X_W
    localparam int CDIV_RCP_SH = CDIV_X_W + CDIV_REM_W;
    localparam int CDIV_RCP_W  = 28;
    localparam logic [CDIV_RCP_W-1:0] CDIV_RCP = CDIV_RCP_W'(
        ((64'd1 << CDIV_RCP_SH) + 64'(CDIV_DIV) - 64'd1) / 64'(CDIV_DIV));

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_TARGET = 2'd1,
        ACT_SETPOS = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // lane commands, one-cycle pulses
    typedef struct packed {
        logic sq_go;
        logic ip_go;
    } lane_cmd_t;

endpackage
`default_nettype wire

@@ rtl/lmi4_lane.sv @@
// One axis lane: span, serial multiply, serial divide by the move length.
`default_nettype none
module lmi4_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lmi4_pkg::lane_cmd_t         cmd,
    input  wire logic [lmi4_pkg::POS_W-1:0]  start_pos,
    input  wire logic [lmi4_pkg::POS_W-1:0]  target_pos,
    input  wire logic [lmi4_pkg::MOVED_W-1:0] moved,
    input  wire logic [lmi4_pkg::LEN_W-1:0]  move_length,
    output logic [lmi4_pkg::SQ_W-1:0]        sq,
    output logic [lmi4_pkg::SPAN_W-1:0]      off,
    output logic                             busy
);
    import lmi4_pkg::*;

    localparam int ACC_W = SPAN_W + MOVED_W;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } lane_state_t;

    lane_state_t          state_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [MOVED_W-1:0]   mplier_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 div_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [SPAN_W-1:0]    span;
    logic                 up;
    logic [LEN_W:0]       trial;
    logic                 ge;

    // span of the move on this axis
    always_comb
    begin
        up   = $signed(target_pos) >= $signed(start_pos);
        span = up ? (target_pos - start_pos) : (start_pos - target_pos);
    end

    // MSB-first shift-add step
    always_comb
    begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                 + (mplier_reg[MOVED_W-1] ? ACC_W'(span) : '0);
    end

    // restoring divide step, quotient shifts into the low accumulator bits
    always_comb
    begin
        trial = {rem_reg, acc_reg[SPAN_W-1]};
        ge    = trial >= {1'b0, move_length};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (cmd.sq_go || cmd.ip_go)
                    begin
                        state_reg <= L_MUL;
                        cnt_reg   <= CNT_W'(MOVED_W - 1);
                        div_reg   <= cmd.ip_go;
                    end
                end
                L_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= div_reg ? L_DIV : L_IDLE;
                        cnt_reg   <= CNT_W'(SPAN_W - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                L_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= L_IDLE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (cmd.sq_go || cmd.ip_go)
                begin
                    acc_reg    <= '0;
                    mplier_reg <= cmd.ip_go ? moved : MOVED_W'(span);
                end
            end
            L_MUL:
            begin
                acc_reg    <= acc_next;
                mplier_reg <= {mplier_reg[MOVED_W-2:0], 1'b0};
                rem_reg    <= acc_next[ACC_W-1:SPAN_W];
            end
            L_DIV:
            begin
                rem_reg <= ge ? LEN_W'(trial - {1'b0, move_length}) : trial[LEN_W-1:0];
                acc_reg <= {acc_reg[ACC_W-1:SPAN_W], acc_reg[SPAN_W-2:0], ge};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign sq   = acc_reg[SQ_W-1:0];
    assign off  = acc_reg[SPAN_W-1:0];
    assign busy = (state_reg != L_IDLE);

endmodule
`default_nettype wire

@@ rtl/lmi4_merge.sv @@
// Merge stage: sums the lane squares and takes the integer square root.
`default_nettype none
module lmi4_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [lmi4_pkg::SQ_W-1:0]   sq [lmi4_pkg::AXES],
    output logic [lmi4_pkg::LEN_W-1:0]       move_length,
    output logic                             busy
);
    import lmi4_pkg::*;

    localparam int REM_W = LEN_W + 1;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_SUM  = 4'b0010,
        M_ROOT = 4'b0100,
        M_WAIT = 4'b1000
    } merge_state_t;

    merge_state_t       state_reg;
    logic [SQ_W:0]      s01_reg;
    logic [SQ_W:0]      s23_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [REM_W+1:0]   t2;
    logic [REM_W+1:0]   trial;
    logic               ge;

    // one root digit per cycle
    always_comb
    begin
        t2    = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial = (REM_W+2)'({root_reg, 2'b01});
        ge    = t2 >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE:
                begin
                    if (go)
                        state_reg <= M_SUM;
                end
                M_SUM:
                begin
                    state_reg <= M_ROOT;
                    cnt_reg   <= CNT_W'(RAD_W / 2 - 1);
                end
                M_ROOT:
                begin
                    if (cnt_reg == '0)
                        state_reg <= M_WAIT;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                M_WAIT:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                s01_reg <= {1'b0, sq[0]} + {1'b0, sq[1]};
                s23_reg <= {1'b0, sq[2]} + {1'b0, sq[3]};
            end
            M_SUM:
            begin
                rad_reg  <= RAD_W'(s01_reg) + RAD_W'(s23_reg);
                rem_reg  <= '0;
                root_reg <= '0;
            end
            M_ROOT:
            begin
                rem_reg  <= ge ? REM_W'(t2 - trial) : t2[REM_W-1:0];
                root_reg <= {root_reg[LEN_W-2:0], ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign move_length = root_reg;
    // busy is low in the hand-back state, once the root is complete
    assign busy = (state_reg != M_IDLE) && (state_reg != M_WAIT);

endmodule
`default_nettype wire

@@ rtl/linear_move_interpolator_4axis_top.sv @@
// Top level of the four-axis time based linear move interpolator.
//
//  channel   dir  handshake                fields
//  s_*       in   s_tvalid / s_tready      tuser: action; tdata: pos x,y,z,e, feed, now_ms
//  m_*       out  m_tvalid / m_tready      tdata: cur x,y,z,e, done_res
//  cfg_*     in   cfg_valid / cfg_ready    min_distance
//
// One item at a time. Set-position and idle updates go straight to the final step.
// Set-target: 33-step lane squaring, sum, 33-step square root. Moving update: 4-step
// divide by 60000 in 16-bit digits, 33-step lane multiply, 32-step lane divide; an
// update that reaches the target skips the lane steps.
// Reset puts the position at zero with no move in progress; min_distance is 66.
// A result waiting on m_tready holds the block only at its final step.
`default_nettype none
module linear_move_interpolator_4axis_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // action
    input  wire logic [175:0] s_tdata,   // pos_x, pos_y, pos_z, pos_e, feed, now_ms
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,   // cur_x, cur_y, cur_z, cur_e, done_res, zero pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data   // min_distance
);
    import lmi4_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_WSQ  = 8'b00000010,
        ST_WRT  = 8'b00000100,
        ST_MULT = 8'b00001000,
        ST_CDIV = 8'b00010000,
        ST_CMP  = 8'b00100000,
        ST_WIP  = 8'b01000000,
        ST_FIN  = 8'b10000000
    } top_state_t;

    top_state_t           state_reg;
    logic [POS_W-1:0]     start_reg  [AXES];
    logic [POS_W-1:0]     target_reg [AXES];
    logic [POS_W-1:0]     cur_reg    [AXES];
    logic [FEED_W-1:0]    feed_reg;
    logic [MS_W-1:0]      start_ms_reg;
    logic [MS_W-1:0]      elapsed_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 idle_reg;
    logic [DIST_W-1:0]    min_dist_reg;
    logic [CDIV_W-1:0]    cdiv_reg;
    logic [CDIV_REM_W-1:0] crem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MOVED_W-1:0]   moved_reg;
    lane_cmd_t            cmd_reg;
    logic                 merge_go_reg;
    logic                 m_tvalid_reg;
    logic [135:0]         m_tdata_reg;

    logic [SQ_W-1:0]      sq_w   [AXES];
    logic [SPAN_W-1:0]    off_w  [AXES];
    logic [AXES-1:0]      busy_w;
    logic [LEN_W-1:0]     root_w;
    logic                 merge_busy;
    logic                 s_acc;
    action_t              act;
    logic [PROD_W-1:0]    prod_w;
    logic [CDIV_X_W-1:0]  cx;
    logic [CDIV_X_W+CDIV_RCP_W-1:0] cprod;
    logic [CDIV_DIG-1:0]  cq;
    logic [CDIV_X_W-1:0]  cqd;
    logic                 reach_w;
    logic                 out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign act       = action_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign prod_w    = PROD_W'(feed_reg) * PROD_W'(elapsed_reg);
    assign reach_w   = cdiv_reg >= CDIV_W'(len_reg);

    // divide-by-1875 step: one 16-bit quotient digit by reciprocal multiply
    always_comb
    begin
        cx    = {crem_reg, cdiv_reg[CDIV_W-1 -: CDIV_DIG]};
        cprod = (CDIV_X_W+CDIV_RCP_W)'(cx) * (CDIV_X_W+CDIV_RCP_W)'(CDIV_RCP);
        cq    = cprod[CDIV_RCP_SH +: CDIV_DIG];
        cqd   = CDIV_X_W'(cq) * CDIV_X_W'(CDIV_DIV);
    end

    // axis lanes
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        lmi4_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd_reg),
            .start_pos   (start_reg[a]),
            .target_pos  (target_reg[a]),
            .moved       (moved_reg),
            .move_length (len_reg),
            .sq          (sq_w[a]),
            .off         (off_w[a]),
            .busy        (busy_w[a])
        );
    end

    lmi4_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (merge_go_reg),
        .sq          (sq_w),
        .move_length (root_w),
        .busy        (merge_busy)
    );

    // control and move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idle_reg     <= 1'b1;
            min_dist_reg <= MIN_DIST_RST;
            cmd_reg      <= '0;
            merge_go_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            feed_reg     <= '0;
            start_ms_reg <= '0;
            len_reg      <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                start_reg[a]  <= '0;
                target_reg[a] <= '0;
                cur_reg[a]    <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                min_dist_reg <= cfg_data;

            // result raised at the final step, dropped once taken
            if (state_reg == ST_FIN && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            // one-cycle start pulses to the lanes and the merge stage
            cmd_reg <= '{sq_go: s_acc && (act == ACT_TARGET),
                         ip_go: (state_reg == ST_CMP) && !reach_w};
            merge_go_reg <= (state_reg == ST_WSQ) && !cmd_reg.sq_go && (busy_w == '0);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        unique case (act)
                            ACT_TARGET:
                            begin
                                for (int a = 0; a < AXES; a++)
                                begin
                                    start_reg[a]  <= cur_reg[a];
                                    target_reg[a] <= s_tdata[a*POS_W +: POS_W];
                                end
                                feed_reg      <= s_tdata[AXES*POS_W +: FEED_W];
                                start_ms_reg  <= s_tdata[AXES*POS_W+FEED_W +: MS_W];
                                state_reg     <= ST_WSQ;
                            end
                            ACT_SETPOS:
                            begin
                                for (int a = 0; a < AXES; a++)
                                    cur_reg[a] <= s_tdata[a*POS_W +: POS_W];
                                idle_reg  <= 1'b1;
                                state_reg <= ST_FIN;
                            end
                            ACT_UPDATE:
                            begin
                                state_reg <= idle_reg ? ST_FIN : ST_MULT;
                            end
                            default:
                            begin
                                state_reg <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_WSQ:
                begin
                    if (!cmd_reg.sq_go && busy_w == '0)
                        state_reg <= ST_WRT;
                end
                ST_WRT:
                begin
                    if (!merge_go_reg && !merge_busy)
                    begin
                        len_reg <= root_w;
                        if (root_w < LEN_W'(min_dist_reg))
                        begin
                            for (int a = 0; a < AXES; a++)
                                cur_reg[a] <= target_reg[a];
                            idle_reg <= 1'b1;
                        end
                        else
                        begin
                            idle_reg <= 1'b0;
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_MULT:
                begin
                    cnt_reg   <= CNT_W'(CDIV_STEPS - 1);
                    state_reg <= ST_CDIV;
                end
                ST_CDIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= ST_CMP;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_CMP:
                begin
                    if (reach_w)
                    begin
                        for (int a = 0; a < AXES; a++)
                            cur_reg[a] <= target_reg[a];
                        idle_reg  <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_WIP;
                    end
                end
                ST_WIP:
                begin
                    if (!cmd_reg.ip_go && busy_w == '0)
                    begin
                        for (int a = 0; a < AXES; a++)
                        begin
                            if ($signed(target_reg[a]) >= $signed(start_reg[a]))
                                cur_reg[a] <= start_reg[a] + off_w[a];
                            else
                                cur_reg[a] <= start_reg[a] - off_w[a];
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // update datapath: elapsed time, product, distance travelled, result word
    always_ff @(posedge clk)
    begin
        if (s_acc)
            elapsed_reg <= s_tdata[AXES*POS_W+FEED_W +: MS_W] - start_ms_reg;
        case (state_reg)
            ST_MULT:
            begin
                cdiv_reg <= CDIV_W'(prod_w) << CDIV_SH;
                crem_reg <= '0;
            end
            ST_CDIV:
            begin
                crem_reg <= CDIV_REM_W'(cx - cqd);
                cdiv_reg <= {cdiv_reg[CDIV_W-CDIV_DIG-1:0], cq};
            end
            ST_CMP:
            begin
                moved_reg <= cdiv_reg[MOVED_W-1:0];
            end
            ST_FIN:
            begin
                if (out_free)
                    m_tdata_reg <= {7'b0, idle_reg, cur_reg[3], cur_reg[2],
                                    cur_reg[1], cur_reg[0]};
            end
            default:
            begin
                cdiv_reg <= cdiv_reg;
            end
        endcase
    end

    // checks
    a_idle_lanes_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (busy_w == '0 && !merge_busy))
        else $error("lane or merge busy while idle");

    a_snap_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && reach_w) |=> idle_reg)
        else $error("move reached length but not done");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside final step");

    a_no_cmd_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CDIV) |-> (cmd_reg == '0))
        else $error("lane command during distance divide");

endmodule
`default_nettype wire

@@ test/tb_linear_move_interpolator_4axis_top.sv @@
// Testbench of the four-axis linear move interpolator: random and directed moves checked against a predictor.
`default_nettype none
module tb_linear_move_interpolator_4axis_top;
    import lmi4_pkg::*;

    // one input item
    typedef struct {
        action_t     act;
        logic [31:0] pos [4];
        logic [15:0] feed;
        logic [31:0] now;
        bit          is_cfg;
        logic [15:0] cfg_val;
    } move_item_t;

    // one expected result
    typedef struct {
        logic [31:0] cur [4];
        logic        done;
    } position_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;   // action
    logic [175:0] s_tdata;   // pos_x, pos_y, pos_z, pos_e, feed, now_ms
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // cur_x, cur_y, cur_z, cur_e, done_res, zero pad
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;  // min_distance

    linear_move_interpolator_4axis_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic signed [63:0] start_p [4];
    logic signed [63:0] target_p [4];
    logic signed [63:0] cur_p [4];
    logic [15:0]        mv_feed;
    logic [31:0]        mv_start;
    logic [63:0]        mv_len;
    logic               idle;
    logic [15:0]        min_dist;

    move_item_t pending_items [$];
    position_t  expected_pos [$];
    int         sender_idle_pct;
    int         receiver_idle_pct;
    int         fail_count;
    int         cycle_count;
    bit         stim_done;

    // integer square root of a 128-bit value
    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // advance the predicted position by one item
    function automatic position_t predict_position(move_item_t it);
        position_t          res;
        logic [127:0]       sum;
        logic [63:0]        m;
        logic [31:0]        elapsed;
        logic [63:0]        prod;
        logic [63:0]        moved;
        logic [127:0]       off;
        sum = 0;
        if (it.act == ACT_TARGET)
        begin
            for (int a = 0; a < 4; a++)
            begin
                start_p[a] = cur_p[a];
                target_p[a] = $signed(it.pos[a]);
                m = (target_p[a] >= start_p[a]) ? target_p[a] - start_p[a]
                                                : start_p[a] - target_p[a];
                sum += {64'd0, m} * {64'd0, m};
            end
            mv_feed = it.feed;
            mv_len = isqrt128(sum);
            mv_start = it.now;
            idle = 1'b0;
            if (mv_len < {48'd0, min_dist})
            begin
                for (int a = 0; a < 4; a++)
                    cur_p[a] = target_p[a];
                idle = 1'b1;
            end
        end
        else if (it.act == ACT_SETPOS)
        begin
            for (int a = 0; a < 4; a++)
                cur_p[a] = $signed(it.pos[a]);
            idle = 1'b1;
        end
        else if (it.act == ACT_UPDATE && !idle)
        begin
            elapsed = it.now - mv_start;
            prod = {48'd0, mv_feed} * {32'd0, elapsed};
            moved = ((prod / MS_PER_MIN) << FRAC_BITS)
                  + (((prod % MS_PER_MIN) << FRAC_BITS) / MS_PER_MIN);
            if (moved >= mv_len)
            begin
                for (int a = 0; a < 4; a++)
                    cur_p[a] = target_p[a];
                idle = 1'b1;
            end
            else
            begin
                for (int a = 0; a < 4; a++)
                begin
                    m = (target_p[a] >= start_p[a]) ? target_p[a] - start_p[a]
                                                    : start_p[a] - target_p[a];
                    off = ({64'd0, m} * {64'd0, moved}) / {64'd0, mv_len};
                    cur_p[a] = (target_p[a] >= start_p[a]) ? start_p[a] + off[63:0]
                                                           : start_p[a] - off[63:0];
                end
            end
        end
        for (int a = 0; a < 4; a++)
            res.cur[a] = cur_p[a][31:0];
        res.done = idle;
        return res;
    endfunction

    // the item at the head of the queue was just accepted
    function automatic bit predict_accept();
        expected_pos.push_back(predict_position(pending_items.pop_front()));
        return 1;
    endfunction

    function automatic logic [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic queue_item(action_t act, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] e,
                              logic [15:0] feed, logic [31:0] now);
        move_item_t it;
        it.act = act;
        it.pos[0] = x;
        it.pos[1] = y;
        it.pos[2] = z;
        it.pos[3] = e;
        it.feed = feed;
        it.now = now;
        it.is_cfg = 0;
        it.cfg_val = 0;
        pending_items.push_back(it);
    endtask

    task automatic queue_cfg(logic [15:0] v);
        move_item_t it;
        it.act = ACT_NONE;
        for (int a = 0; a < 4; a++)
            it.pos[a] = '0;
        it.feed = '0;
        it.now = '0;
        it.is_cfg = 1;
        it.cfg_val = v;
        pending_items.push_back(it);
    endtask

    // random moves: a target then a run of updates, with some noise
    task automatic queue_random(int n, logic [31:0] base_ms);
        logic [31:0] t;
        int          upd;
        int          k;
        int          mode;
        t = base_ms;
        k = 0;
        while (k < n)
        begin
            mode = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0: queue_item(ACT_SETPOS, rand_pos(mode), rand_pos(mode), rand_pos(mode),
                              rand_pos(mode), 16'($urandom), $urandom);
                1: queue_item(action_t'($urandom_range(0, 3)), $urandom, $urandom,
                              $urandom, $urandom, 16'($urandom), $urandom);
                default:
                begin
                    t = t + $urandom_range(0, 5);
                    queue_item(ACT_TARGET, rand_pos(mode), rand_pos(mode), rand_pos(mode),
                               rand_pos(mode), ($urandom_range(0, 7) == 0) ? 16'($urandom)
                               : 16'($urandom_range(0, 3000)), t);
                    upd = $urandom_range(1, 12);
                    k += upd;
                    for (int u = 0; u < upd; u++)
                    begin
                        t = t + (($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 400));
                        queue_item(ACT_UPDATE, $urandom, $urandom, $urandom, $urandom,
                                   16'($urandom), t);
                    end
                end
            endcase
            k++;
        end
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // stimulus
    initial
    begin
        rst_n = 0;
        sender_idle_pct = 23;
        receiver_idle_pct = 76;
        stim_done = 0;
        for (int a = 0; a < 4; a++)
        begin
            start_p[a] = 0;
            target_p[a] = 0;
            cur_p[a] = 0;
        end
        mv_feed = 0;
        mv_start = 0;
        mv_len = 0;
        idle = 1;
        min_dist = 16'd66;

        // directed: extremes, every action, special cases
        queue_item(ACT_UPDATE, '1, '1, '1, '1, '1, 32'd100);
        queue_item(ACT_NONE, '1, '1, '1, '1, '1, '1);
        queue_item(ACT_TARGET, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   16'hffff, 32'hfffffff0);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'h00000010);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'h00100000);
        queue_item(ACT_SETPOS, 32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 0, 0);
        queue_item(ACT_TARGET, 32'h80000000, 32'h7fffffff, 0, 32'hffffffff, 16'd500, 0);
        queue_item(ACT_TARGET, 32'h80000010, 32'h7fffffff, 0, 32'hffffffff, 16'd500, 0);
        queue_item(ACT_TARGET, 32'h00100000, 32'hfff00000, 32'h00050000, 32'h0, 16'd0, 5);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'd50000);
        queue_item(ACT_SETPOS, 0, 0, 0, 0, 0, 0);
        queue_item(ACT_TARGET, 32'h00a00000, 32'hff600000, 32'h00300000, 32'hffd00000,
                   16'd1200, 32'd1000);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'd1100);
        queue_item(ACT_TARGET, 32'hff000000, 32'h01000000, 0, 32'h00010000, 16'd3000, 32'd1200);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'd1300);
        queue_item(ACT_NONE, 0, 0, 0, 0, 0, 0);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'd1299);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'hffffffff);
        queue_cfg(16'd0);
        queue_item(ACT_TARGET, 32'hff000000, 32'h01000000, 0, 32'h00010000, 16'd100, 32'd7);
        queue_item(ACT_UPDATE, 0, 0, 0, 0, 0, 32'd7);
        queue_cfg(16'hffff);
        queue_item(ACT_TARGET, 32'hff00ffff, 32'h01000000, 0, 32'h00010000, 16'd100, 32'd7);
        queue_random(450, 32'hffffff00);
        queue_cfg(16'd66);
        queue_random(450, 32'd0);
        queue_cfg(16'd3000);
        queue_random(450, 32'h80000000);
        stim_done = 1;

        repeat (8) @(posedge clk);
        rst_n <= 1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 0;
            s_tuser   <= '0;
            s_tdata   <= '0;
            cfg_valid <= 0;
            cfg_data  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_ready)
                cfg_valid <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                void'(predict_accept());
            if (pending_items.size() > 0 && pending_items[0].is_cfg)
            begin
                // registers change only once the block has gone quiet
                s_tvalid <= 0;
                if (expected_pos.size() == 0 && !s_tvalid)
                begin
                    repeat (150) @(posedge clk);
                    min_dist = pending_items[0].cfg_val;
                    cfg_data <= pending_items[0].cfg_val;
                    cfg_valid <= 1;
                    void'(pending_items.pop_front());
                    if (pending_items.size() < 1000 && sender_idle_pct == 23)
                    begin
                        sender_idle_pct = 76;
                        receiver_idle_pct = 23;
                    end
                    else if (sender_idle_pct == 76)
                    begin
                        sender_idle_pct = 0;
                        receiver_idle_pct = 0;
                    end
                end
            end
            else if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                s_tvalid <= 1;
                s_tuser  <= pending_items[0].act;
                s_tdata  <= {pending_items[0].now, pending_items[0].feed,
                             pending_items[0].pos[3], pending_items[0].pos[2],
                             pending_items[0].pos[1], pending_items[0].pos[0]};
            end
            else
                s_tvalid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        position_t exp_r;
        if (!rst_n)
        begin
            m_tready <= 0;
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pos.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_pos.pop_front();
                    for (int a = 0; a < 4; a++)
                        if (m_tdata[32*a +: 32] !== exp_r.cur[a])
                        begin
                            $display("%0t: axis %0d expected %h actual %h", $time, a,
                                     exp_r.cur[a], m_tdata[32*a +: 32]);
                            fail_count++;
                        end
                    if (m_tdata[128] !== exp_r.done)
                    begin
                        $display("%0t: done expected %b actual %b", $time, exp_r.done,
                                 m_tdata[128]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // end of run and timeout
    initial
    begin
        cycle_count = 0;
        @(posedge rst_n);
        while (!(stim_done && pending_items.size() == 0 && !s_tvalid
                 && expected_pos.size() == 0) && cycle_count < 2000000)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= 2000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            repeat (300) @(posedge clk);
            if (fail_count == 0 && expected_pos.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
            $finish;
        end
    end
endmodule
`default_nettype wire
